FILE: design/battery_level_gauge_hysteresis_macros.svh
// Assertion helpers used by the checker file of the battery gauge.
`ifndef BATTERY_LEVEL_GAUGE_HYSTERESIS_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_HYSTERESIS_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define BLG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A transaction offered but not taken stays offered with the same payload.
`define BLG_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

FILE: design/blg_pkg.sv
package blg_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned NUM_THR      = 6;
  localparam int unsigned NUM_LEVELS   = 7;
  localparam int unsigned VOLT_W       = 10;
  localparam int unsigned LEVEL_W      = 3;
  localparam int unsigned TRIES_W      = 3;
  localparam int unsigned MARGIN_W     = 5;
  localparam int unsigned BAR_W        = 4;
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 32;

  // Register indexes on the configuration port (address bits [4:2]).
  localparam logic [2:0] REG_THR_30V    = 3'd0;
  localparam logic [2:0] REG_THR_41V    = 3'd1;
  localparam logic [2:0] REG_THR_43V8   = 3'd2;
  localparam logic [2:0] REG_THR_46V4   = 3'd3;
  localparam logic [2:0] REG_THR_49V    = 3'd4;
  localparam logic [2:0] REG_THR_51V5   = 3'd5;
  localparam logic [2:0] REG_DROP_STEP  = 3'd6;
  localparam logic [2:0] REG_DROP_TRIES = 3'd7;

  localparam logic [VOLT_W-1:0] THR_30V_RST    = 10'd464;
  localparam logic [VOLT_W-1:0] THR_41V_RST    = 10'd631;
  localparam logic [VOLT_W-1:0] THR_43V8_RST   = 10'd669;
  localparam logic [VOLT_W-1:0] THR_46V4_RST   = 10'd704;
  localparam logic [VOLT_W-1:0] THR_49V_RST    = 10'd744;
  localparam logic [VOLT_W-1:0] THR_51V5_RST   = 10'd775;
  localparam logic [VOLT_W-1:0] DROP_STEP_RST  = 10'd250;
  localparam logic [TRIES_W-1:0] DROP_TRIES_RST = 3'd5;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 3'd6;
  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_SEG   = 3'd2;

  // Rise margin over the band threshold, per battery and level (level 0 unused).
  localparam logic [MARGIN_W-1:0] RISE_MARGIN [2][NUM_LEVELS] = '{
    '{5'd0, 5'd17, 5'd20, 5'd10, 5'd12, 5'd12, 5'd15},
    '{5'd0, 5'd20, 5'd20, 5'd10, 5'd10, 5'd10, 5'd10}
  };

  typedef struct packed {
    logic [NUM_THR-1:0][VOLT_W-1:0] thr;
    logic [VOLT_W-1:0]              drop_step;
    logic [TRIES_W-1:0]             drop_tries;
  } cfg_t;

  typedef struct packed {
    logic              channel;
    logic [VOLT_W-1:0] adc_sample;
  } sample_t;

  typedef struct packed {
    logic               out_channel;
    logic [VOLT_W-1:0]  held_voltage;
    logic [LEVEL_W-1:0] level;
    logic               low_blink;
    logic               first_seg_on;
    logic [BAR_W-1:0]   bar_pattern;
  } result_t;

  typedef struct packed {
    logic [VOLT_W-1:0]  last_voltage;
    logic [TRIES_W-1:0] dropout_count;
    logic [LEVEL_W-1:0] shown_level;
    logic               blink_flag;
  } chan_state_t;

  function automatic logic [BAR_W-1:0] bar_of_level(input logic [LEVEL_W-1:0] lvl);
    logic [BAR_W-1:0] bar;
    unique case (lvl)
      3'd3:    bar = 4'b1000;
      3'd4:    bar = 4'b1100;
      3'd5:    bar = 4'b1110;
      3'd6:    bar = 4'b1111;
      default: bar = 4'b0000;
    endcase
    return bar;
  endfunction

endpackage

FILE: design/blg_stream_if.sv
interface blg_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

FILE: design/battery_level_gauge_hysteresis.sv
// Channel    Direction  Handshake       Payload
// sample_i   in         valid / ready   channel, adc_sample
// result_o   out        valid / ready   out_channel, held_voltage, level, low_blink,
//                                       first_seg_on, bar_pattern
// APB        in         psel / penable  paddr, pwdata, prdata (pready tied high)
//
// One sample transaction is taken every cycle while the result side is not stalled.
// A result is offered once its sample has passed the input register and then the
// result register.
// The per-battery state is read, updated and written back in the same cycle that
// the result register loads, so back-to-back samples of one battery chain cleanly.
// Reset clears the pipeline valid bits, loads the register defaults and puts
// battery 0 at full level and every other battery at empty.
// When the result is stalled both stages hold; the input stage still takes a new
// sample while it is empty.
module battery_level_gauge_hysteresis #(
  parameter int unsigned CHANNELS = blg_pkg::CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  blg_stream_if.sink                   sample_i,
  blg_stream_if.source                 result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]  paddr,
  input  logic [blg_pkg::PDATA_W-1:0]  pwdata,
  output logic [blg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import blg_pkg::*;

  // Only batteries that the one-bit channel field can name need storage.
  localparam int unsigned NSLOT = (CHANNELS > 2) ? 2 : CHANNELS;

  cfg_t        cfg;
  logic        in_vld_q;
  sample_t     in_q;
  logic        res_vld_q;
  result_t     res_q;
  logic        advance;
  logic        upd;
  chan_state_t st_rd;
  chan_state_t st_wr;
  result_t     res_d;
  chan_state_t slot_q [NSLOT];

  blg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register moves whenever it is empty or being drained; the input
  // register follows it.
  assign advance        = !res_vld_q || result_o.ready;
  assign sample_i.ready = !in_vld_q || advance;
  assign result_o.valid = res_vld_q;
  assign result_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      in_q <= sample_i.data;
    end
  end

  always_comb begin
    st_rd = slot_q[0];
    if ((NSLOT > 1) && in_q.channel) begin
      st_rd = slot_q[NSLOT-1];
    end
  end

  blg_eval #(
    .CHANNELS (CHANNELS)
  ) u_eval (
    .sample_i (in_q),
    .st_i     (st_rd),
    .cfg_i    (cfg),
    .st_o     (st_wr),
    .res_o    (res_d),
    .upd_o    (upd)
  );

  for (genvar s = 0; s < NSLOT; s++) begin : g_slot
    localparam logic [LEVEL_W-1:0] LvlRst = (s == 0) ? LEVEL_FULL : LEVEL_EMPTY;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[s].last_voltage  <= '0;
        slot_q[s].dropout_count <= '0;
        slot_q[s].shown_level   <= LvlRst;
        slot_q[s].blink_flag    <= 1'b0;
      end else if (advance && in_vld_q && upd && (32'(in_q.channel) == s)) begin
        slot_q[s] <= st_wr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: design/blg_cfg.sv
module blg_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blg_pkg::PADDR_W-1:0]   paddr,
  input  logic [blg_pkg::PDATA_W-1:0]   pwdata,
  output logic [blg_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output blg_pkg::cfg_t                 cfg_o
);
  import blg_pkg::*;

  cfg_t        cfg_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr[0]      <= THR_30V_RST;
      cfg_q.thr[1]      <= THR_41V_RST;
      cfg_q.thr[2]      <= THR_43V8_RST;
      cfg_q.thr[3]      <= THR_46V4_RST;
      cfg_q.thr[4]      <= THR_49V_RST;
      cfg_q.thr[5]      <= THR_51V5_RST;
      cfg_q.drop_step   <= DROP_STEP_RST;
      cfg_q.drop_tries  <= DROP_TRIES_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THR_30V:    cfg_q.thr[0]     <= pwdata[VOLT_W-1:0];
        REG_THR_41V:    cfg_q.thr[1]     <= pwdata[VOLT_W-1:0];
        REG_THR_43V8:   cfg_q.thr[2]     <= pwdata[VOLT_W-1:0];
        REG_THR_46V4:   cfg_q.thr[3]     <= pwdata[VOLT_W-1:0];
        REG_THR_49V:    cfg_q.thr[4]     <= pwdata[VOLT_W-1:0];
        REG_THR_51V5:   cfg_q.thr[5]     <= pwdata[VOLT_W-1:0];
        REG_DROP_STEP:  cfg_q.drop_step  <= pwdata[VOLT_W-1:0];
        REG_DROP_TRIES: cfg_q.drop_tries <= pwdata[TRIES_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_THR_30V:    prdata[VOLT_W-1:0]  = cfg_q.thr[0];
      REG_THR_41V:    prdata[VOLT_W-1:0]  = cfg_q.thr[1];
      REG_THR_43V8:   prdata[VOLT_W-1:0]  = cfg_q.thr[2];
      REG_THR_46V4:   prdata[VOLT_W-1:0]  = cfg_q.thr[3];
      REG_THR_49V:    prdata[VOLT_W-1:0]  = cfg_q.thr[4];
      REG_THR_51V5:   prdata[VOLT_W-1:0]  = cfg_q.thr[5];
      REG_DROP_STEP:  prdata[VOLT_W-1:0]  = cfg_q.drop_step;
      REG_DROP_TRIES: prdata[TRIES_W-1:0] = cfg_q.drop_tries;
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: design/blg_eval.sv
module blg_eval #(
  parameter int unsigned CHANNELS = blg_pkg::CHANNELS_DEF
) (
  input  blg_pkg::sample_t     sample_i,
  input  blg_pkg::chan_state_t st_i,
  input  blg_pkg::cfg_t        cfg_i,
  output blg_pkg::chan_state_t st_o,
  output blg_pkg::result_t     res_o,
  output logic                 upd_o
);
  import blg_pkg::*;

  logic                       in_range;
  logic [VOLT_W-1:0]          v;
  logic [VOLT_W-1:0]          old_v;
  logic [VOLT_W-1:0]          fall;
  logic                       dropout;
  logic [TRIES_W-1:0]         cnt_inc;
  logic [NUM_THR-1:0]         ge;
  logic [NUM_THR-1:0][VOLT_W-1:0] excess;
  logic [NUM_LEVELS-1:0]      hit;
  logic [NUM_LEVELS-1:0]      take;
  logic [LEVEL_W-1:0]         prev_lvl;
  logic [LEVEL_W-1:0]         lvl;
  logic                       blink;

  assign in_range = 32'(sample_i.channel) < CHANNELS;
  assign upd_o    = in_range;

  always_comb begin
    old_v   = st_i.last_voltage;
    v       = sample_i.adc_sample;
    fall    = old_v - sample_i.adc_sample;
    dropout = (old_v > sample_i.adc_sample) && (fall > cfg_i.drop_step);
    cnt_inc = st_i.dropout_count + 3'd1;
    st_o    = st_i;

    // A large fall is held off until it has been seen drop_tries times.
    if (dropout) begin
      if (cnt_inc < cfg_i.drop_tries) begin
        v                  = old_v;
        st_o.dropout_count = cnt_inc;
      end else begin
        st_o.dropout_count = '0;
      end
    end
    st_o.last_voltage = v;

    for (int k = 0; k < NUM_THR; k++) begin
      ge[k]     = v >= cfg_i.thr[k];
      excess[k] = v - cfg_i.thr[k];
    end

    hit[0]            = !ge[0];
    hit[NUM_LEVELS-1] = ge[NUM_THR-1];
    for (int b = 1; b < NUM_LEVELS - 1; b++) begin
      hit[b] = ge[b-1] && !ge[b];
    end

    prev_lvl = st_i.shown_level;
    take[0]  = hit[0];
    for (int b = 1; b < NUM_LEVELS; b++) begin
      take[b] = hit[b] && ((prev_lvl >= 3'(b)) ||
                (excess[b-1] > {5'd0, RISE_MARGIN[sample_i.channel][b]}));
    end

    // Bands are checked in rising order; the highest band taken wins.
    lvl   = prev_lvl;
    blink = st_i.blink_flag;
    for (int b = 0; b < NUM_LEVELS; b++) begin
      if (take[b]) begin
        lvl   = 3'(b);
        blink = (b == 1);
      end
    end
    st_o.shown_level = lvl;
    st_o.blink_flag  = blink;

    res_o.out_channel = sample_i.channel;
    if (in_range) begin
      res_o.held_voltage = v;
      res_o.level        = lvl;
      res_o.low_blink    = blink;
      res_o.first_seg_on = lvl >= LEVEL_SEG;
      res_o.bar_pattern  = bar_of_level(lvl);
    end else begin
      res_o.held_voltage = sample_i.adc_sample;
      res_o.level        = LEVEL_EMPTY;
      res_o.low_blink    = 1'b0;
      res_o.first_seg_on = 1'b0;
      res_o.bar_pattern  = '0;
    end
  end

endmodule

FILE: design/blg_checker.sv
`include "battery_level_gauge_hysteresis_macros.svh"

module blg_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             vld_i,
  input logic             rdy_i,
  input blg_pkg::result_t res_i
);
  import blg_pkg::*;

  logic blink_ok;
  logic seg_ok;

  // The blink flag belongs to level one only, and the first segment to level two and up.
  assign blink_ok = !res_i.low_blink || (res_i.level == LEVEL_LOW);
  assign seg_ok   = res_i.first_seg_on == (res_i.level >= LEVEL_SEG);

  `BLG_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, vld_i, rdy_i, res_i, "result moved while stalled")
  `BLG_ASSERT(a_lvl_range, clk_i, rst_ni, vld_i |-> (res_i.level <= LEVEL_FULL), "level above full")
  `BLG_ASSERT(a_blink_low, clk_i, rst_ni, vld_i |-> blink_ok, "blink outside low level")
  `BLG_ASSERT(a_seg_match, clk_i, rst_ni, vld_i |-> seg_ok, "first segment disagrees with level")

endmodule

bind battery_level_gauge_hysteresis blg_checker u_blg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .vld_i  (result_o.valid),
  .rdy_i  (result_o.ready),
  .res_i  (result_o.data)
);

FILE: bench/tb_battery_level_gauge_hysteresis.sv
`timescale 1ns / 100ps

// Self-checking bench for the battery level gauge. Samples go in on one stream
// and readouts come back on the other. A behavioral copy of the gauge in this
// file (dropout rejection, band sort, rise hysteresis) predicts every readout,
// and the monitor compares each returned transaction field by field against the
// oldest prediction still waiting.
module tb_battery_level_gauge_hysteresis;
  import blg_pkg::*;

  // Rise margins per battery and level, and the bar shown for each level.
  localparam int GAUGE_MARGIN [2][7] = '{
    '{0, 17, 20, 10, 12, 12, 15},
    '{0, 20, 20, 10, 10, 10, 10}
  };
  localparam logic [3:0] GAUGE_BAR [7] = '{4'd0, 4'd0, 4'd0, 4'd8, 4'd12, 4'd14, 4'd15};

  localparam int LONG_HOLD    = 60;
  localparam int PHASE_ITEMS  = 113;
  localparam int DRAIN_LIMIT  = 100000;

  typedef enum int {
    SET_DEFAULT,
    SET_ALL_LOW,
    SET_ALL_HIGH,
    SET_RANDOM,
    SET_ASCENDING
  } setting_kind_e;

  // One row of the directed part. Where typed is set, the readout is written
  // out by hand and checked as is; other rows are checked against the model.
  typedef struct packed {
    logic    ch;
    logic [VOLT_W-1:0] volt;
    logic    typed;
    result_t res;
  } gauge_row_t;

  localparam int ROW_COUNT = 22;
  localparam gauge_row_t GAUGE_ROWS [ROW_COUNT] = '{
    // Fresh out of reset: battery 0 starts full, battery 1 empty.
    '{1'b0, 10'd1023, 1'b1, '{1'b0, 10'd1023, 3'd6, 1'b0, 1'b1, 4'd15}},
    '{1'b1, 10'd0,    1'b1, '{1'b1, 10'd0,    3'd0, 1'b0, 1'b0, 4'd0}},
    '{1'b1, 10'd1023, 1'b1, '{1'b1, 10'd1023, 3'd6, 1'b0, 1'b1, 4'd15}},
    // Full-scale fall on battery 1: held four times, taken on the fifth.
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    '{1'b1, 10'd0,    1'b0, '0},
    // Rise into level one below the margin, then above it, then a rise
    // into level two that misses its margin, a jump to level three, and a fall.
    '{1'b1, 10'd470,  1'b0, '0},
    '{1'b1, 10'd490,  1'b0, '0},
    '{1'b1, 10'd640,  1'b0, '0},
    '{1'b1, 10'd700,  1'b0, '0},
    '{1'b1, 10'd500,  1'b0, '0},
    // Dropout sightings on battery 0 separated by a normal sample: the count
    // survives the normal sample.
    '{1'b0, 10'd480,  1'b0, '0},
    '{1'b0, 10'd1000, 1'b0, '0},
    '{1'b0, 10'd0,    1'b0, '0},
    '{1'b0, 10'd750,  1'b0, '0},
    '{1'b0, 10'd760,  1'b0, '0},
    '{1'b0, 10'd780,  1'b0, '0},
    '{1'b0, 10'd791,  1'b0, '0},
    '{1'b1, 10'd1023, 1'b0, '0},
    '{1'b1, 10'd512,  1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  blg_stream_if #(.data_t(sample_t)) sample_if ();
  blg_stream_if #(.data_t(result_t)) result_if ();

  battery_level_gauge_hysteresis uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk_i = ~clk_i;

  // Register copies and per-battery state of the behavioral gauge.
  logic [VOLT_W-1:0]  gauge_thr [NUM_THR];
  logic [VOLT_W-1:0]  gauge_drop_step;
  logic [TRIES_W-1:0] gauge_drop_tries;
  chan_state_t        gauge_chan [2];

  result_t readouts_due [$];

  int  mismatches;
  int  samples_sent;
  int  readouts_seen;
  int  dropouts_held;
  int  settings_used;
  int  phase_items;
  bit  pressure_phase;
  bit  quiet;
  int  hold_requests;
  int  holds_done;

  // Idle gaps: mostly none, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [VOLT_W-1:0] clamp_volt(input int x);
    if (x < 0) return '0;
    if (x > 1023) return 10'd1023;
    return x[VOLT_W-1:0];
  endfunction

  // Behavioral gauge: dropout rejection first, then the bands are scanned from
  // the bottom up and the last band that is both hit and allowed wins. A rise
  // needs the sample to clear the band threshold by the battery's margin.
  function automatic result_t gauge_predict(input sample_t s);
    chan_state_t        st;
    result_t            r;
    logic [VOLT_W-1:0]  v;
    logic [TRIES_W-1:0] cnt;
    logic [LEVEL_W-1:0] lvl;
    logic               blink;
    bit                 hit;
    bit                 take;
    st = gauge_chan[s.channel];
    v  = s.adc_sample;
    if (st.last_voltage > v && (st.last_voltage - v) > gauge_drop_step) begin
      cnt = st.dropout_count + 3'd1;
      if (cnt < gauge_drop_tries) begin
        v = st.last_voltage;
        st.dropout_count = cnt;
        dropouts_held++;
      end else begin
        st.dropout_count = '0;
      end
    end
    st.last_voltage = v;
    lvl   = st.shown_level;
    blink = st.blink_flag;
    for (int b = 0; b < 7; b++) begin
      if (b == 0) hit = v < gauge_thr[0];
      else if (b == 6) hit = v >= gauge_thr[5];
      else hit = v >= gauge_thr[b-1] && v < gauge_thr[b];
      if (hit) begin
        take = (b == 0) || (st.shown_level >= b) ||
               (int'(v) - int'(gauge_thr[b-1]) > GAUGE_MARGIN[s.channel][b]);
        if (take) begin
          lvl   = b[LEVEL_W-1:0];
          blink = (b == 1);
        end
      end
    end
    st.shown_level = lvl;
    st.blink_flag  = blink;
    gauge_chan[s.channel] = st;
    r.out_channel  = s.channel;
    r.held_voltage = v;
    r.level        = lvl;
    r.low_blink    = blink;
    r.first_seg_on = (lvl >= 3'd2);
    r.bar_pattern  = GAUGE_BAR[lvl];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // Offer one sample after a random gap and wait for the transaction. The
  // prediction is queued at the accepting edge; a typed row replaces it.
  task automatic drive_sample(input sample_t s, input logic typed, input result_t typed_res);
    int      gap;
    result_t pred;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      sample_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk_i); while (!sample_if.ready);
    pred = gauge_predict(s);
    readouts_due.push_back(typed ? typed_res : pred);
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted readout has been returned.
  task automatic drain_readouts();
    int guard;
    guard = 0;
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (readouts_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Random sample with the pressure events of the phase folded in: a long
  // stall of the result side while samples keep coming, and later a pause
  // of the sample side until the gauge has emptied.
  task automatic send_random(input logic ch, input logic [VOLT_W-1:0] v);
    sample_t s;
    s.channel    = ch;
    s.adc_sample = v;
    drive_sample(s, 1'b0, '0);
    phase_items++;
    if (pressure_phase && phase_items == 40) hold_requests++;
    if (pressure_phase && phase_items == 80) drain_readouts();
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load a whole register set, keep the gauge copy in step, and read every
  // register back.
  task automatic apply_setting(input setting_kind_e kind);
    int                 tv [$];
    logic [PDATA_W-1:0] rd;
    logic [PDATA_W-1:0] want;
    tv.delete();
    case (kind)
      SET_DEFAULT: begin
        tv = '{464, 631, 669, 704, 744, 775, 250, 5};
      end
      SET_ALL_LOW: begin
        tv = '{0, 0, 0, 0, 0, 0, 0, 1};
      end
      SET_ALL_HIGH: begin
        tv = '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 7};
      end
      SET_ASCENDING: begin
        repeat (6) tv.push_back($urandom_range(300, 900));
        tv.sort();
        tv.push_back($urandom_range(50, 400));
        tv.push_back($urandom_range(1, 7));
      end
      default: begin
        repeat (6) tv.push_back($urandom_range(0, 1023));
        tv.push_back($urandom_range(0, 1023));
        tv.push_back($urandom_range(1, 7));
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      apb_write(REG_THR_30V + i[2:0], tv[i]);
      gauge_thr[i] = tv[i][VOLT_W-1:0];
    end
    apb_write(REG_DROP_STEP, tv[6]);
    gauge_drop_step = tv[6][VOLT_W-1:0];
    apb_write(REG_DROP_TRIES, tv[7]);
    gauge_drop_tries = tv[7][TRIES_W-1:0];
    for (int i = 0; i < 8; i++) begin
      apb_read(i[2:0], rd);
      want = tv[i];
      if (i[2:0] == REG_DROP_TRIES) begin
        if (rd[TRIES_W-1:0] != want[TRIES_W-1:0])
          report_mismatch($sformatf("register %0d read %0d, wrote %0d", i,
                                    rd[TRIES_W-1:0], want[TRIES_W-1:0]));
      end else if (rd[VOLT_W-1:0] != want[VOLT_W-1:0]) begin
        report_mismatch($sformatf("register %0d read %0d, wrote %0d", i,
                                  rd[VOLT_W-1:0], want[VOLT_W-1:0]));
      end
    end
    settings_used++;
  endtask

  // One random phase made of short episodes: slow walks from the battery's
  // current voltage, hovering around a threshold, dropout bursts of up to one
  // more than the tries setting, and a little uniform noise.
  task automatic run_phase(input int quota);
    int                kind;
    int                n;
    int                base;
    int                thr_v;
    logic              ch;
    logic [VOLT_W-1:0] low;
    phase_items = 0;
    while (phase_items < quota) begin
      kind = $urandom_range(0, 9);
      ch   = $urandom_range(0, 1);
      base = gauge_chan[ch].last_voltage;
      if (kind <= 4) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          base = clamp_volt(base + $urandom_range(0, 60) - 30);
          send_random(ch, base[VOLT_W-1:0]);
        end
      end else if (kind <= 6) begin
        thr_v = gauge_thr[$urandom_range(0, 5)];
        n = $urandom_range(1, 4);
        repeat (n) send_random(ch, clamp_volt(thr_v + $urandom_range(0, 40) - 20));
      end else if (kind <= 8 && base > gauge_drop_step) begin
        low = $urandom_range(0, base - gauge_drop_step - 1);
        n = $urandom_range(1, gauge_drop_tries + 1);
        repeat (n) send_random(ch, low);
      end else begin
        send_random(ch, $urandom_range(0, 1023));
      end
    end
  endtask

  // Result side: random stalls, plus the long hold-off when one is requested.
  initial begin : result_sink
    int stall;
    stall = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Every returned transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin : readout_check
    result_t want;
    result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      readouts_seen++;
      got = result_if.data;
      if (readouts_due.size() == 0) begin
        report_mismatch($sformatf("readout with nothing pending: ch %0d volt %0d lvl %0d",
                                  got.out_channel, got.held_voltage, got.level));
      end else begin
        want = readouts_due.pop_front();
        check_field("out_channel", want.out_channel, got.out_channel);
        check_field("held_voltage", want.held_voltage, got.held_voltage);
        check_field("level", want.level, got.level);
        check_field("low_blink", want.low_blink, got.low_blink);
        check_field("first_seg_on", want.first_seg_on, got.first_seg_on);
        check_field("bar_pattern", want.bar_pattern, got.bar_pattern);
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("tb_battery_level_gauge_hysteresis: errors");
    $finish;
  end

  initial begin : stimulus
    sample_t       s;
    setting_kind_e plan [6];
    mismatches     = 0;
    samples_sent   = 0;
    readouts_seen  = 0;
    dropouts_held  = 0;
    settings_used  = 1;
    phase_items    = 0;
    pressure_phase = 1'b0;
    quiet          = 1'b0;
    hold_requests  = 0;
    holds_done     = 0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;

    // Gauge copy matches the reset state of the block.
    gauge_thr        = '{464, 631, 669, 704, 744, 775};
    gauge_drop_step  = 10'd250;
    gauge_drop_tries = 3'd5;
    gauge_chan[0]    = '{last_voltage: '0, dropout_count: '0, shown_level: 3'd6,
                         blink_flag: 1'b0};
    gauge_chan[1]    = '0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < ROW_COUNT; i++) begin
      s.channel    = GAUGE_ROWS[i].ch;
      s.adc_sample = GAUGE_ROWS[i].volt;
      drive_sample(s, GAUGE_ROWS[i].typed, GAUGE_ROWS[i].res);
    end

    // Register settings for the random phases: both extremes, scrambled
    // and ordered thresholds, and the defaults once more with no idling.
    plan = '{SET_ALL_LOW, SET_ALL_HIGH, SET_RANDOM, SET_ASCENDING, SET_DEFAULT, SET_RANDOM};
    foreach (plan[p]) begin
      drain_readouts();
      repeat (4) @(posedge clk_i);
      apply_setting(plan[p]);
      pressure_phase = (plan[p] == SET_ASCENDING);
      quiet          = (plan[p] == SET_DEFAULT);
      run_phase(PHASE_ITEMS);
    end
    quiet = 1'b0;

    drain_readouts();
    repeat (10) @(posedge clk_i);
    if (readouts_due.size() != 0) begin
      report_mismatch($sformatf("%0d readouts never returned", readouts_due.size()));
    end

    $display("Covered %0d samples under %0d register settings, %0d of them held as dropouts.",
             samples_sent, settings_used, dropouts_held);
    $display("Compared %0d readouts; %0d mismatches.", readouts_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_battery_level_gauge_hysteresis: clean");
    end else begin
      $display("tb_battery_level_gauge_hysteresis: errors");
    end
    $finish;
  end

endmodule
